FILE: hdl/skgr_pkg.sv
// Package for the k-group stream reverser.
// Holds shared constants, the controller state type and the datapath command struct.
// No dependencies.
package skgr_pkg;

    localparam int P_MAX_GROUP = 16;
    localparam int P_VALUE_W   = 32;
    localparam int P_CFG_W     = 5;
    localparam logic [P_CFG_W-1:0] P_CFG_RESET = 5'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

    // command from controller to datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic run_end;
        logic list_last;
    } t_dp_cmd;

endpackage

FILE: hdl/skgr_in_if.sv
// Input channel of the k-group stream reverser: valid/ready plus one list element.
// Depends on skgr_pkg.
interface skgr_in_if
    import skgr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [P_VALUE_W-1:0] value;
    logic                 list_end;

    modport source (output valid, output value, output list_end, input ready);
    modport sink   (input valid, input value, input list_end, output ready);
endinterface

FILE: hdl/skgr_out_if.sv
// Output channel of the k-group stream reverser: valid/ready plus one reordered element.
// Depends on skgr_pkg.
interface skgr_out_if
    import skgr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [P_VALUE_W-1:0] out_value;
    logic                 run_end;
    logic                 list_last;

    modport source (output valid, output out_value, output run_end, output list_last,
                    input ready);
    modport sink   (input valid, input out_value, input run_end, input list_last,
                    output ready);
endinterface

FILE: hdl/skgr_datapath.sv
// Datapath of the k-group stream reverser: group buffer memory and output payload register.
// Depends on skgr_pkg; driven by skgr_ctrl.
module skgr_datapath
    import skgr_pkg::*;
#(
    parameter int MAX_GROUP = P_MAX_GROUP
) (
    input  logic                         i_clk,
    input  t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_GROUP)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_GROUP)-1:0] i_rd_addr,
    input  logic [P_VALUE_W-1:0]         i_wr_data,
    output logic [P_VALUE_W-1:0]         o_value,
    output logic                         o_run_end,
    output logic                         o_list_last
);

    logic [P_VALUE_W-1:0] r_mem [MAX_GROUP];
    logic [P_VALUE_W-1:0] r_value;
    logic                 r_run_end;
    logic                 r_list_last;

    // buffer write, one item per accepted input
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read feeds the output payload directly
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_value     <= r_mem[i_rd_addr];
            r_run_end   <= i_cmd.run_end;
            r_list_last <= i_cmd.list_last;
        end
    end

    assign o_value     = r_value;
    assign o_run_end   = r_run_end;
    assign o_list_last = r_list_last;

endmodule

FILE: hdl/skgr_ctrl.sv
// Controller of the k-group stream reverser: group size register, fill count,
// readout sequencing and channel handshakes. Depends on skgr_pkg.
module skgr_ctrl
    import skgr_pkg::*;
#(
    parameter int MAX_GROUP = P_MAX_GROUP
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [P_CFG_W-1:0]           i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_list_end,
    output logic                         o_in_ready,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output t_dp_cmd                      o_cmd,
    output logic [$clog2(MAX_GROUP)-1:0] o_wr_addr,
    output logic [$clog2(MAX_GROUP)-1:0] o_rd_addr
);

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > P_CFG_W) ? CW : P_CFG_W;

    t_state               r_state, n_state;
    logic [P_CFG_W-1:0]   r_gsize;
    logic [CW-1:0]        r_fill, n_fill;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_rev, n_rev;
    logic                 r_last, n_last;

    logic [KW-1:0]        w_gs_ext;
    logic [KW-1:0]        w_k;
    logic [CW-1:0]        w_push;
    logic [CW-1:0]        w_fill_inc;
    logic [CW-1:0]        w_src;
    logic                 w_tail;
    logic                 w_accept;

    // group size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsize <= P_CFG_RESET;
        end else if (i_cfg_we) begin
            r_gsize <= i_cfg_data;
        end
    end

    // effective group size: saturate at MAX_GROUP, 0 and 1 mean pass-through
    always_comb begin
        w_gs_ext = KW'(r_gsize);
        if (w_gs_ext > KW'(MAX_GROUP)) begin
            w_k = KW'(MAX_GROUP);
        end else if (w_gs_ext < KW'(2)) begin
            w_k = KW'(1);
        end else begin
            w_k = w_gs_ext;
        end
    end

    // push slot and readout addressing
    assign w_push     = (r_fill >= CW'(MAX_GROUP)) ? CW'(MAX_GROUP - 1) : r_fill;
    assign w_fill_inc = w_push + CW'(1);
    assign w_src      = r_rev ? (r_count - CW'(1) - r_idx) : r_idx;
    assign w_tail     = ((r_idx + CW'(1)) == r_count);
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_wr_addr  = w_push[AW-1:0];
    assign o_rd_addr  = w_src[AW-1:0];
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_rev   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_rev   <= n_rev;
            r_last  <= n_last;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_fill          = r_fill;
        n_count         = r_count;
        n_idx           = r_idx;
        n_rev           = r_rev;
        n_last          = r_last;
        o_cmd.wr_en     = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.run_end   = w_tail;
        o_cmd.list_last = w_tail && r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.wr_en = 1'b1;
                    n_fill      = w_fill_inc;
                    n_last      = i_in_list_end;
                    n_count     = w_fill_inc;
                    n_idx       = '0;
                    if (KW'(w_fill_inc) >= w_k) begin
                        // group complete: newest first
                        n_rev   = 1'b1;
                        n_state = ST_READ;
                    end else if (i_in_list_end) begin
                        // partial group at list end: arrival order
                        n_rev   = 1'b0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_SEND;
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    if (w_tail) begin
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/stream_k_group_reverser_top.sv
// Top level of the k-group stream reverser. Depends on skgr_pkg, skgr_in_if,
// skgr_out_if, skgr_ctrl and skgr_datapath.
//
// Takes a list one signed 32-bit element per item and returns it reversed in
// groups of group_size elements (saturated at MAX_GROUP; 0 and 1 pass items
// through); a trailing partial group comes out in arrival order when the item
// flagged list_end arrives. run_end marks the last result of each group and
// list_last the last result of the list. Each result is read from the group
// buffer into the output register (ST_READ) and then held there and offered
// (ST_SEND) until the output takes it.
// No input is taken while a group is being read out. group_size is written
// through i_cfg_we/i_cfg_data and takes effect on the next item.
module stream_k_group_reverser_top
    import skgr_pkg::*;
#(
    parameter int MAX_GROUP = P_MAX_GROUP
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [P_CFG_W-1:0] i_cfg_data,
    skgr_in_if.sink            i_in,
    skgr_out_if.source         o_out
);

    localparam int AW = $clog2(MAX_GROUP);

    t_dp_cmd        w_cmd;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;

    skgr_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in.valid),
        .i_in_list_end (i_in.list_end),
        .o_in_ready    (i_in.ready),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_cmd         (w_cmd),
        .o_wr_addr     (w_wr_addr),
        .o_rd_addr     (w_rd_addr)
    );

    skgr_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_wr_addr   (w_wr_addr),
        .i_rd_addr   (w_rd_addr),
        .i_wr_data   (i_in.value),
        .o_value     (o_out.out_value),
        .o_run_end   (o_out.run_end),
        .o_list_last (o_out.list_last)
    );

endmodule

FILE: hdl/skgr_checker.sv
// Port-level checks for the k-group stream reverser, bound to the top level.
// Depends on skgr_pkg and stream_k_group_reverser_top.
module skgr_checker
    import skgr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [P_VALUE_W-1:0] i_out_value,
    input logic                 i_out_run_end,
    input logic                 i_out_list_last
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_run_end) && $stable(i_out_list_last))
        else $error("stalled result changed");

    // the end of the list is always the end of a run
    a_last_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_run_end || !i_out_list_last)
        else $error("list_last without run_end");

    // input is never taken while a result is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready during readout");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 && i_rst_n |-> !i_out_valid && i_in_ready)
        else $error("result pending after reset");

endmodule

bind stream_k_group_reverser_top skgr_checker u_skgr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_value     (o_out.out_value),
    .i_out_run_end   (o_out.run_end),
    .i_out_list_last (o_out.list_last)
);

FILE: sim/tb_top.sv
// Testbench for stream_k_group_reverser_top: random and directed lists checked
// item by item against an in-bench model of the k-group LIFO reordering.
// Depends on skgr_pkg, skgr_in_if, skgr_out_if and the RTL top level.
module tb_top;
    import skgr_pkg::*;

    typedef struct packed {
        logic [P_VALUE_W-1:0] value;
        logic                 list_end;
    } t_elem;

    typedef struct packed {
        logic [P_VALUE_W-1:0] out_value;
        logic                 run_end;
        logic                 list_last;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [P_CFG_W-1:0] i_cfg_data;

    skgr_in_if  in_ch ();
    skgr_out_if out_ch ();

    stream_k_group_reverser_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    // elements waiting to be sent, and reordered elements still owed by the block
    t_elem   pending_elems [$];
    t_result reordered_q [$];

    // model state: LIFO of buffered elements and the group size last written
    logic [P_VALUE_W-1:0] group_stack [P_MAX_GROUP];
    int                   stack_fill;
    logic [P_CFG_W-1:0]   group_size_cfg;

    int  error_count;
    int  queued_count;
    int  taken_count;
    bit  in_taken;
    bit  calm;
    int  send_gap;
    int  recv_stall;

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = ~i_clk;
    end

    // push one element onto the model LIFO and queue whatever it releases
    function automatic void push_and_reorder(logic [P_VALUE_W-1:0] value, logic ends_list);
        int  k;
        int  n;
        int  src;
        bit  reversed;
        t_result r;
        k = (group_size_cfg > P_MAX_GROUP) ? P_MAX_GROUP : int'(group_size_cfg);
        if (k < 2) begin
            k = 1;
        end
        if (stack_fill >= P_MAX_GROUP) begin
            stack_fill = P_MAX_GROUP - 1;
        end
        group_stack[stack_fill] = value;
        stack_fill++;
        if (stack_fill >= k) begin
            reversed = 1'b1;
        end else if (ends_list) begin
            reversed = 1'b0;
        end else begin
            return;
        end
        n = stack_fill;
        for (int i = 0; i < n; i++) begin
            src = reversed ? (n - 1 - i) : i;
            r.out_value = group_stack[src];
            r.run_end   = (i == n - 1);
            r.list_last = (i == n - 1) && ends_list;
            reordered_q.push_back(r);
        end
        stack_fill = 0;
    endfunction

    // mostly no gap, some short ones, a few long; none while calm
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report(string field, logic [P_VALUE_W-1:0] exp_v, logic [P_VALUE_W-1:0] got_v);
        $display("mismatch on %s: expected %h, got %h", field, exp_v, got_v);
        error_count++;
    endtask

    // input driver: holds an item until taken, then applies the next after a gap
    always @(negedge i_clk) begin
        t_elem e;
        if (i_rst_n && !(in_ch.valid && !in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_elems.size() > 0) begin
                e = pending_elems.pop_front();
                in_ch.valid    <= 1'b1;
                in_ch.value    <= e.value;
                in_ch.list_end <= e.list_end;
                send_gap = pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    // monitor: predict on accepted inputs, check accepted outputs
    always @(posedge i_clk) begin
        t_result exp_r;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                push_and_reorder(in_ch.value, in_ch.list_end);
                taken_count++;
                in_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (reordered_q.size() == 0) begin
                    report("unexpected item", '0, out_ch.out_value);
                end else begin
                    exp_r = reordered_q.pop_front();
                    if (out_ch.out_value !== exp_r.out_value) begin
                        report("out_value", exp_r.out_value, out_ch.out_value);
                    end
                    if (out_ch.run_end !== exp_r.run_end) begin
                        report("run_end", exp_r.run_end, out_ch.run_end);
                    end
                    if (out_ch.list_last !== exp_r.list_last) begin
                        report("list_last", exp_r.list_last, out_ch.list_last);
                    end
                end
            end
        end
    end

    task automatic queue_elem(logic [P_VALUE_W-1:0] value, logic ends_list);
        t_elem e;
        e.value    = value;
        e.list_end = ends_list;
        pending_elems.push_back(e);
        queued_count++;
    endtask

    // wait until every item is taken and every result seen, then let the block settle
    task automatic wait_drained();
        while (taken_count != queued_count || reordered_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_group_size(logic [P_CFG_W-1:0] size);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        group_size_cfg = size;
    endtask

    function automatic logic [P_VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // one list of random content; the end flag only if asked
    task automatic queue_list(int len, bit terminate);
        for (int i = 0; i < len; i++) begin
            queue_elem(random_value(), terminate && (i == len - 1));
        end
    endtask

    // stimulus
    initial begin
        int rand_items;
        int len;
        int nlists;
        logic [P_CFG_W-1:0] size;

        error_count    = 0;
        queued_count   = 0;
        taken_count    = 0;
        in_taken       = 1'b0;
        calm           = 1'b0;
        send_gap       = 0;
        recv_stall     = 0;
        stack_fill     = 0;
        group_size_cfg = P_CFG_RESET;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.list_end = 1'b0;
        out_ch.ready   = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size of 2: one reversed pair, then a lone trailing element
        queue_elem(32'h8000_0000, 1'b0);
        queue_elem(32'h7FFF_FFFF, 1'b0);
        queue_elem(32'hFFFF_FFFF, 1'b1);

        // sizes 0 and 1 pass through
        write_group_size(5'd0);
        queue_elem(32'h0000_0000, 1'b1);
        write_group_size(5'd1);
        queue_elem(32'h0000_0001, 1'b0);

        // oversized group saturates at 16; list ends exactly on a full group
        write_group_size(5'd31);
        for (int i = 0; i < 16; i++) begin
            queue_elem(32'h1000_0000 + i, i == 15);
        end

        // size lowered below the current fill flushes the whole buffer reversed
        write_group_size(5'd6);
        queue_elem(32'h0000_00A1, 1'b0);
        queue_elem(32'h0000_00A2, 1'b0);
        write_group_size(5'd2);
        queue_elem(32'h0000_00A3, 1'b0);

        // partial group at list end keeps arrival order
        write_group_size(5'd4);
        queue_elem(32'h5555_5555, 1'b0);
        queue_elem(32'hAAAA_AAAA, 1'b1);

        // random phases: new size each phase, a few lists, some left open
        rand_items = 0;
        while (rand_items < 460) begin
            case ($urandom_range(0, 9))
                0: size = 5'd0;
                1: size = 5'd1;
                2: size = 5'd31;
                3: size = 5'd16;
                4: size = P_CFG_W'($urandom_range(17, 30));
                5: size = P_CFG_W'($urandom_range(9, 15));
                default: size = P_CFG_W'($urandom_range(2, 8));
            endcase
            write_group_size(size);
            calm = ($urandom_range(0, 3) == 0);
            nlists = $urandom_range(1, 3);
            for (int l = 0; l < nlists; l++) begin
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(1, 40);
                end else begin
                    len = $urandom_range(1, 2 * ((size < 2) ? 1 : int'(size)) + 3);
                end
                queue_list(len, (l != nlists - 1) || ($urandom_range(0, 7) != 0));
                rand_items += len;
            end
        end

        wait_drained();
        repeat (6) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/skgr_pkg.sv
hdl/skgr_in_if.sv
hdl/skgr_out_if.sv
hdl/skgr_datapath.sv
hdl/skgr_ctrl.sv
hdl/stream_k_group_reverser_top.sv
hdl/skgr_checker.sv
sim/tb_top.sv
